>>> rtl/core/sbus_pkg.sv
// Shared types and constants for the serial remote-control frame receiver.
// No dependencies; imported by the frame receiver, the checker and the testbench top.
package sbus_pkg;

    // Frame layout
    localparam int FRAME_BYTES  = 25;
    localparam int FRAME_ADDR_W = $clog2(FRAME_BYTES);
    localparam int CHANNELS     = 16;
    localparam int CH_BITS      = 11;

    localparam logic [7:0] START_BYTE   = 8'h0F;
    localparam logic [7:0] END_BYTE     = 8'h00;
    localparam logic [FRAME_ADDR_W-1:0] FLAG_ADDR = FRAME_ADDR_W'(23);
    localparam logic [FRAME_ADDR_W-1:0] LAST_ADDR = FRAME_ADDR_W'(FRAME_BYTES - 1);
    localparam int FAILSAFE_POS = 3;
    localparam logic [CH_BITS-1:0] CH_MASK = 11'h7FF;
    localparam logic [15:0] GOOD_MAX = 16'hFFFF;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES = 2'd2;
    localparam logic [9:0]  TICK_INC_RST  = 10'd10;
    localparam logic [15:0] WIN_LIMIT_RST = 16'd1000;
    localparam logic [7:0]  MIN_FRAMES_RST = 8'd5;

    // Item kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic [7:0]  frame_flags;
        logic        receiver_failsafe;
        logic        signal_lost;
        logic        window_end;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IN,
        ST_FLAG_RD,
        ST_FLAG_CAP,
        ST_RD,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/core/sbus_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sbus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sbus_frame_receiver.sv
// Serial frame receiver: byte and tick items in, channel and tick status beats out.
// A tick beat is registered and shown in the cycle after its item is taken. After a
// good frame's final byte the flag byte is read, then each channel's three bytes come
// through the frame RAM's single read port, and its beat waits while the output stalls.
// Reset is synchronous, active low: control registers to defaults, lost flag set; the
// frame RAM and the payload registers are not cleared.
module sbus_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sbus_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sbus_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [sbus_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbus_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import sbus_pkg::*;

    t_state r_state, n_state;
    logic [FRAME_ADDR_W-1:0] r_fill, n_fill;
    logic [15:0] r_good, n_good;
    logic [15:0] r_window, n_window;
    logic        r_lost, n_lost;
    logic [9:0]  r_tick_inc;
    logic [15:0] r_win_limit;
    logic [7:0]  r_min_frames;
    logic [3:0]  r_ch, n_ch;
    logic [1:0]  r_k, n_k;
    logic [23:0] r_word, n_word;
    logic [7:0]  r_flags, n_flags;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic                    ram_we;
    logic [FRAME_ADDR_W-1:0] ram_raddr;
    logic [7:0]              ram_rdata;

    logic        out_free;
    logic        in_accept;
    logic [7:0]  bitpos;
    logic [FRAME_ADDR_W-1:0] base;
    logic [16:0] tick_sum;
    logic        ch_last;

    sbus_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill),
        .i_wdata (i_in_data.byte_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake helpers
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IN) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Channel bit position and first byte of its window
    assign bitpos   = 8'(r_ch) * 8'd11;
    assign base     = FRAME_ADDR_W'(1) + FRAME_ADDR_W'(bitpos >> 3);
    assign tick_sum = {1'b0, r_window} + {7'b0, r_tick_inc};
    assign ch_last  = (r_ch == 4'(CHANNELS - 1));

    // Next state, datapath and RAM control
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_good      = r_good;
        n_window    = r_window;
        n_lost      = r_lost;
        n_ch        = r_ch;
        n_k         = r_k;
        n_word      = r_word;
        n_flags     = r_flags;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ram_we      = 1'b0;
        ram_raddr   = FLAG_ADDR;

        case (r_state)
            ST_IN: begin
                if (in_accept) begin
                    if (i_in_data.mode == MODE_TICK) begin
                        // Advance window timer; close window on overrun
                        n_out = '0;
                        n_out.kind = KIND_TICK;
                        n_out.last = 1'b1;
                        if (tick_sum > {1'b0, r_win_limit}) begin
                            n_window = '0;
                            n_lost   = (r_good <= {8'b0, r_min_frames});
                            n_good   = '0;
                            n_out.window_end  = 1'b1;
                            n_out.signal_lost = (r_good <= {8'b0, r_min_frames});
                        end else begin
                            n_window = tick_sum[15:0];
                            n_out.signal_lost = r_lost;
                        end
                        n_out_valid = 1'b1;
                    end else if (!(r_fill == '0 && i_in_data.byte_value != START_BYTE)) begin
                        // Store byte; on the last one check the end byte
                        ram_we = 1'b1;
                        if (r_fill == LAST_ADDR) begin
                            n_fill = '0;
                            if (i_in_data.byte_value == END_BYTE) begin
                                n_state = ST_FLAG_RD;
                            end
                        end else begin
                            n_fill = r_fill + FRAME_ADDR_W'(1);
                        end
                    end
                end
            end
            ST_FLAG_RD: begin
                ram_raddr = FLAG_ADDR;
                n_state   = ST_FLAG_CAP;
            end
            ST_FLAG_CAP: begin
                // Hold flag byte and count the frame if not in failsafe
                n_flags = ram_rdata;
                if (!ram_rdata[FAILSAFE_POS] && r_good != GOOD_MAX) begin
                    n_good = r_good + 16'd1;
                end
                n_ch    = '0;
                n_k     = '0;
                n_state = ST_RD;
            end
            ST_RD: begin
                // Issue byte k, capture byte k-1
                ram_raddr = base + FRAME_ADDR_W'(r_k);
                case (r_k)
                    2'd1:    n_word[7:0]   = ram_rdata;
                    2'd2:    n_word[15:8]  = ram_rdata;
                    2'd3:    n_word[23:16] = ram_rdata;
                    default: n_word        = r_word;
                endcase
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out.kind              = KIND_CHANNEL;
                    n_out.channel_index     = r_ch;
                    n_out.channel_value     = 11'(r_word >> bitpos[2:0]) & CH_MASK;
                    n_out.frame_flags       = r_flags;
                    n_out.receiver_failsafe = r_flags[FAILSAFE_POS];
                    n_out.signal_lost       = r_lost;
                    n_out.window_end        = 1'b0;
                    n_out.last              = ch_last;
                    n_out_valid             = 1'b1;
                    n_k = '0;
                    if (ch_last) begin
                        n_state = ST_IN;
                    end else begin
                        n_ch    = r_ch + 4'd1;
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IN;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IN;
            r_fill      <= '0;
            r_good      <= '0;
            r_window    <= '0;
            r_lost      <= 1'b1;
            r_ch        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_good      <= n_good;
            r_window    <= n_window;
            r_lost      <= n_lost;
            r_ch        <= n_ch;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_flags <= n_flags;
        r_out   <= n_out;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_inc   <= TICK_INC_RST;
            r_win_limit  <= WIN_LIMIT_RST;
            r_min_frames <= MIN_FRAMES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TICK_INC:   r_tick_inc   <= i_cfg_data[9:0];
                CFG_WIN_LIMIT:  r_win_limit  <= i_cfg_data;
                CFG_MIN_FRAMES: r_min_frames <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Fill position stays inside the frame
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LAST_ADDR)
        else $error("fill position beyond frame");

    // A byte on the last position wraps the fill position
    a_fill_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_data.mode == MODE_BYTE && r_fill == LAST_ADDR) |=> r_fill == '0)
        else $error("fill position did not wrap");

    // The last channel beat returns the receiver to taking items
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && ch_last) |=> (r_state == ST_IN && o_out_data.last))
        else $error("frame emission did not finish");

endmodule

>>> tb/sbus_frame_checker.sv
// Checker for the serial frame receiver: follows the byte/tick and channel beat channels.
// Keeps its own copy of the receiver state and registers, and compares every output beat.
// Depends on sbus_pkg for the beat types and the frame constants.
module sbus_frame_checker
    import sbus_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Receiver copy: frame bytes, fill pointer, window counters
    logic [7:0]  frame_mem [FRAME_BYTES];
    logic [4:0]  fill_pos;
    logic [15:0] good_cnt;
    logic [15:0] win_time;
    logic        lost;

    // Register copy
    logic [9:0]  tick_inc;
    logic [15:0] win_limit;
    logic [7:0]  min_good;

    t_out_item   due_beats [$];
    t_out_item   want;
    int          fail_total = 0;
    int          beat_no = 0;

    task automatic report(input string msg);
        fail_total++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val) begin
            report($sformatf("beat %0d %s: got %0d, want %0d", beat_no, name, got, exp_val));
        end
    endtask

    // Advance the receiver copy by one accepted item and queue the beats it causes
    function automatic void receive_item(input t_in_item it);
        t_out_item   b;
        logic [16:0] sum;
        logic [23:0] word;
        logic [7:0]  flags;
        int          bitpos;
        int          base;

        if (it.mode == MODE_TICK) begin
            sum = {1'b0, win_time} + 17'(tick_inc);
            b = '0;
            b.kind = KIND_TICK;
            b.last = 1'b1;
            if (sum > {1'b0, win_limit}) begin
                // close the window: judge the signal and restart the count
                b.window_end = 1'b1;
                win_time = '0;
                lost = (good_cnt <= 16'(min_good));
                good_cnt = '0;
            end else begin
                win_time = sum[15:0];
            end
            b.signal_lost = lost;
            due_beats.push_back(b);
            return;
        end

        // drop bytes while hunting for the start byte
        if (fill_pos == 0 && it.byte_value != START_BYTE) begin
            return;
        end
        frame_mem[fill_pos] = it.byte_value;
        fill_pos++;
        if (fill_pos < FRAME_BYTES) begin
            return;
        end
        fill_pos = '0;
        if (frame_mem[LAST_ADDR] != END_BYTE) begin
            return;
        end

        flags = frame_mem[FLAG_ADDR];
        if (!flags[FAILSAFE_POS] && good_cnt != GOOD_MAX) begin
            good_cnt++;
        end

        // unpack eleven-bit channels, little-endian from byte 1
        for (int ch = 0; ch < CHANNELS; ch++) begin
            bitpos = ch * CH_BITS;
            base = 1 + bitpos / 8;
            word = '0;
            for (int k = 0; k < 3; k++) begin
                if (base + k < FRAME_BYTES) begin
                    word |= 24'(frame_mem[base + k]) << (8 * k);
                end
            end
            b = '0;
            b.kind = KIND_CHANNEL;
            b.channel_index = 4'(ch);
            b.channel_value = 11'(word >> (bitpos % 8)) & CH_MASK;
            b.frame_flags = flags;
            b.receiver_failsafe = flags[FAILSAFE_POS];
            b.signal_lost = lost;
            b.last = (ch == CHANNELS - 1);
            due_beats.push_back(b);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_pos = '0;
            good_cnt = '0;
            win_time = '0;
            lost = 1'b1;
            tick_inc = TICK_INC_RST;
            win_limit = WIN_LIMIT_RST;
            min_good = MIN_FRAMES_RST;
            due_beats.delete();
        end else begin
            // register writes, masked to each register's width
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TICK_INC:   tick_inc = i_cfg_data[9:0];
                    CFG_WIN_LIMIT:  win_limit = i_cfg_data[15:0];
                    CFG_MIN_FRAMES: min_good = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                receive_item(i_in_data);
            end

            // compare each output beat with the oldest one due
            if (i_out_valid && !i_out_stall) begin
                if (due_beats.size() == 0) begin
                    report($sformatf("beat %0d arrived with nothing due", beat_no));
                end else begin
                    want = due_beats.pop_front();
                    check_field("kind", i_out_data.kind, want.kind);
                    check_field("channel_index", i_out_data.channel_index,
                                want.channel_index);
                    check_field("channel_value", i_out_data.channel_value,
                                want.channel_value);
                    check_field("frame_flags", i_out_data.frame_flags, want.frame_flags);
                    check_field("receiver_failsafe", i_out_data.receiver_failsafe,
                                want.receiver_failsafe);
                    check_field("signal_lost", i_out_data.signal_lost, want.signal_lost);
                    check_field("window_end", i_out_data.window_end, want.window_end);
                    check_field("last", i_out_data.last, want.last);
                end
                beat_no++;
            end
        end
        o_pending <= due_beats.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> tb/tb.sv
// Testbench top for the serial frame receiver: clock, reset, register writes and stimulus.
// Directed frames and ticks first, then random frames, noise and ticks over several settings.
// Depends on sbus_pkg, sbus_frame_receiver and sbus_frame_checker.
module tb;
    import sbus_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int CLK_PERIOD     = 2 * HALF_PERIOD;
    localparam int DRAIN_CYCLES   = 120;
    localparam int TIMEOUT_CYCLES = 500000;
    localparam int PHASE_ITEMS    = 75;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  quiet = 1'b0;
    int                    gap_pct = 0;
    int                    fail_count;
    int                    pending;

    always #HALF_PERIOD clk = ~clk;

    sbus_frame_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sbus_frame_checker frame_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Present one item, after an optional gap, and hold it until accepted
    task automatic send_item(input logic is_tick, input logic [7:0] value);
        t_in_item it;
        int       gap;

        gap = 0;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 18);
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.mode = is_tick;
        it.byte_value = value;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Send a frame of len bytes, with ticks scattered between bytes
    task automatic send_frame(input int fill, input logic [7:0] flags,
                              input logic [7:0] tail, input int len, input int tick_pct);
        logic [7:0] b;

        for (int i = 0; i < len; i++) begin
            if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct) begin
                send_item(MODE_TICK, 8'($urandom));
            end
            if (i == 0) begin
                b = START_BYTE;
            end else if (i == FLAG_ADDR) begin
                b = flags;
            end else if (i == LAST_ADDR) begin
                b = tail;
            end else begin
                case (fill)
                    FILL_ZEROS: b = 8'h00;
                    FILL_ONES:  b = 8'hFF;
                    default:    b = 8'($urandom);
                endcase
            end
            send_item(MODE_BYTE, b);
        end
    endtask

    // Drop valid, wait for every due beat, then let the block finish any frame work
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] tick, input logic [15:0] limit,
                            input logic [15:0] min_cnt);
        write_reg(CFG_TICK_INC, tick);
        write_reg(CFG_WIN_LIMIT, limit);
        write_reg(CFG_MIN_FRAMES, min_cnt);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed frames with random content, plus tick runs, noise and broken frames
    task automatic random_phase(input int n_items);
        int         sent;
        int         pick;
        int         len;
        int         fill;
        int         tick_pct;
        logic [7:0] flags;
        logic [7:0] tail;

        sent = 0;
        while (sent < n_items) begin
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise while hunting; does not count
                send_item(MODE_BYTE, 8'($urandom));
            end else if (pick < 28) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(MODE_TICK, 8'($urandom));
                    sent++;
                end
            end else begin
                pick = $urandom_range(0, 9);
                fill = (pick == 0) ? FILL_ZEROS : (pick == 1) ? FILL_ONES : FILL_RANDOM;
                flags = 8'($urandom);
                if ($urandom_range(0, 9) < 7) begin
                    flags[FAILSAFE_POS] = 1'b0;
                end
                tail = ($urandom_range(0, 99) < 85) ? END_BYTE : 8'($urandom_range(1, 255));
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(2, FRAME_BYTES - 1)
                                                   : FRAME_BYTES;
                tick_pct = ($urandom_range(0, 1) == 0) ? 0 : 8;
                send_frame(fill, flags, tail, len, tick_pct);
                sent += len;
            end
        end
    endtask

    // Receiver stall: random bursts, with occasional long clear stretches
    initial begin
        @(posedge clk);
        forever begin
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else if ($urandom_range(0, 7) == 0) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(40, 120)) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(0, 1) == 1);
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default registers, noise, tick, full-scale, failsafe and bad-end-byte frames
        set_regs(TICK_INC_RST, WIN_LIMIT_RST, MIN_FRAMES_RST);
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_TICK, 8'hFF);
        send_frame(FILL_ONES, 8'h00, END_BYTE, FRAME_BYTES, 0);
        send_frame(FILL_ZEROS, 8'hFF, END_BYTE, FRAME_BYTES, 0);
        send_frame(FILL_RANDOM, 8'h00, 8'h80, FRAME_BYTES, 0);
        settle();

        // Every tick closes a window: one good frame clears the lost flag, none sets it
        set_regs(16'd1000, 16'd1, 16'd0);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_TICK, 8'h00);
        random_phase(PHASE_ITEMS);
        settle();

        // Widest window, highest threshold
        set_regs(16'd1, 16'd65535, 16'd255);
        random_phase(PHASE_ITEMS);
        settle();

        // Random mid-range settings, junk in the upper data bits and the spare index
        write_reg(CFG_SPARE, 16'($urandom));
        set_regs({6'($urandom), 10'($urandom_range(20, 400))},
                 16'($urandom_range(50, 800)),
                 {8'($urandom), 8'($urandom_range(0, 3))});
        random_phase(PHASE_ITEMS);
        settle();

        // Final stretch with no idling on either side
        set_regs(16'd250, 16'd500, 16'd1);
        quiet <= 1'b1;
        gap_pct = 0;
        random_phase(PHASE_ITEMS);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
